FILE: rtl/lsjc_pkg.sv
// Shared types, constants and ramp function for the log-scaled jet colormap.
package lsjc_pkg;

   localparam int SAMPLE_BITS  = 32;
   localparam int RATIO_BITS   = 16;
   localparam int CHANNEL_BITS = 8;

   // log2(1e5) in Q.16
   localparam int unsigned LOG2_1E5_Q16 = 1088529;

   typedef logic signed [19:0] lsjc_ramp_type;

   localparam lsjc_ramp_type ONE_Q16   = 20'sd65536;
   localparam lsjc_ramp_type RED_RISE  = 20'sd98304;
   localparam lsjc_ramp_type RED_FALL  = 20'sd294912;
   localparam lsjc_ramp_type GRN_RISE  = 20'sd32768;
   localparam lsjc_ramp_type GRN_FALL  = 20'sd229376;
   localparam lsjc_ramp_type BLU_RISE  = -20'sd32768;
   localparam lsjc_ramp_type BLU_FALL  = 20'sd163840;

   typedef struct packed {
      logic busy;
      logic done;
   } lsjc_status_type;

   function automatic logic [16:0] ramp(input lsjc_ramp_type rise, input lsjc_ramp_type fall);
      lsjc_ramp_type c;
      c = (rise < fall) ? rise : fall;
      if (c < 0) begin
         c = '0;
      end
      if (c > ONE_Q16) begin
         c = ONE_Q16;
      end
      return c[16:0];
   endfunction

endpackage

FILE: rtl/lsjc_log.sv
// Multi-cycle log2 unit: binary-search normalize, then one squaring per fraction bit.
module lsjc_log #(
   parameter int LOG_FRAC_BITS = 10
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic [lsjc_pkg::SAMPLE_BITS-1:0]         value,
   output lsjc_pkg::lsjc_status_type                status,
   output logic signed [LOG_FRAC_BITS+7:0]          result
);
   import lsjc_pkg::*;

   localparam int NORM_STEPS = 5;
   localparam int NSTEPS     = NORM_STEPS + LOG_FRAC_BITS;
   localparam int STEP_W     = $clog2(NSTEPS);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_W-1:0]        cnt_ff, cnt_in;
   logic [31:0]              m_ff, m_in;
   logic [4:0]               lead_ff, lead_in;
   logic [LOG_FRAC_BITS-1:0] frac_ff, frac_in;

   logic [4:0]  shift_amt;
   logic [31:0] norm_mask;
   logic [63:0] square;
   logic [32:0] sq;
   logic [5:0]  int_part;

   always_comb begin
      shift_amt = 5'(5'd16 >> cnt_ff);
      norm_mask = ~(32'hFFFF_FFFF >> shift_amt);
      square    = 64'(m_ff) * 64'(m_ff);
      sq        = square[63:31];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      m_in    = m_ff;
      lead_in = lead_ff;
      frac_in = frac_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         m_in    = value;
         lead_in = 5'd31;
         frac_in = '0;
      end else if (busy_ff) begin
         if (cnt_ff < STEP_W'(NORM_STEPS)) begin
            if ((m_ff & norm_mask) == 32'd0) begin
               m_in    = m_ff << shift_amt;
               lead_in = lead_ff - shift_amt;
            end
         end else begin
            frac_in = {frac_ff[LOG_FRAC_BITS-2:0], sq[32]};
            m_in    = sq[32] ? sq[32:1] : sq[31:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(NSTEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      lead_ff <= lead_in;
      frac_ff <= frac_in;
   end

   assign int_part    = 6'({1'b0, lead_ff}) - 6'd16;
   assign result      = {{2{int_part[5]}}, int_part, frac_ff};
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: rtl/lsjc_div.sv
// Radix-2 restoring divider giving a Q0.16 ratio of a smaller numerator to a denominator.
module lsjc_div #(
   parameter int WIDTH = 18
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [WIDTH-1:0]                    numer,
   input  logic [WIDTH-1:0]                    denom,
   output lsjc_pkg::lsjc_status_type           status,
   output logic [lsjc_pkg::RATIO_BITS-1:0]     quotient
);
   import lsjc_pkg::*;

   localparam int CNT_W = $clog2(RATIO_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [WIDTH-1:0]      rem_ff, rem_in;
   logic [WIDTH-1:0]      den_ff, den_in;
   logic [RATIO_BITS-1:0] q_ff, q_in;
   logic [WIDTH-1:0]      rem_dbl;

   always_comb begin
      rem_dbl = {rem_ff[WIDTH-2:0], 1'b0};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = numer;
         den_in  = denom;
         q_in    = '0;
      end else if (busy_ff) begin
         if (rem_dbl >= den_ff) begin
            rem_in = rem_dbl - den_ff;
            q_in   = {q_ff[RATIO_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_dbl;
            q_in   = {q_ff[RATIO_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RATIO_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign quotient    = q_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: rtl/log_scaled_jet_colormap.sv
// Top level of the log-scaled jet colormap: scan statistics, log ratio and color ramps.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    tuser {restart, operation}, tdata sample
//   rsp      out        rsp_tvalid/tready    tdata {blue, green, red}
//
// Scan item: updates the largest and smallest samples, no result.
// Color item: passes the log unit (LOG_FRAC_BITS + 5 steps) and, unless the ratio saturates,
// the 16-step divider; a zero sample or empty frame skips both and gives black.
// The first color item after scan items that is not black also logs the largest and smallest.
// Reset clears the statistics; no item is taken while a color item is at work, and a
// finished result waits in the output register while req_tready returns high.
module log_scaled_jet_colormap #(
   parameter int LOG_FRAC_BITS = 10,
   parameter int COLOR_BITS    = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // operation, restart
   input  logic [31:0] req_tdata,   // sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red, green, blue
);
   import lsjc_pkg::*;

   localparam int LW = LOG_FRAC_BITS + 8;
   localparam int unsigned L1E5_TWICE = (LOG2_1E5_Q16 * 2) >> (16 - LOG_FRAC_BITS);
   localparam int unsigned L1E5_LOG   = (L1E5_TWICE + 1) >> 1;
   localparam logic signed [LW-1:0] LOG_1E5 = LW'(L1E5_LOG);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LMAX  = 3'd1;
   localparam logic [2:0] ST_LMIN  = 3'd2;
   localparam logic [2:0] ST_LSMP  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_COLOR = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic                    stats_valid_ff, stats_valid_in;
   logic [SAMPLE_BITS-1:0]  largest_ff, largest_in;
   logic [SAMPLE_BITS-1:0]  smallest_ff, smallest_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [23:0]             rsp_data_ff, rsp_data_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic                    black_ff, black_in;
   logic signed [LW-1:0]    lmax_ff, lmax_in;
   logic signed [LW-1:0]    lmin_ff, lmin_in;
   logic [RATIO_BITS-1:0]   ratio_ff, ratio_in;

   logic                    req_accept;
   logic [SAMPLE_BITS-1:0]  req_sample;
   logic                    log_start;
   logic [SAMPLE_BITS-1:0]  log_value;
   lsjc_status_type         log_status;
   logic signed [LW-1:0]    log_result;
   logic                    div_start;
   lsjc_status_type         div_status;
   logic [RATIO_BITS-1:0]   div_quotient;
   logic signed [LW-1:0]    num;
   logic signed [LW-1:0]    den;
   lsjc_ramp_type           t;
   logic [7:0]              red, green, blue;

   function automatic logic [7:0] to_color(input logic [16:0] c);
      logic [33:0] scaled;
      scaled = (34'(c) << COLOR_BITS) - 34'(c) + 34'd32768;
      return scaled[23:16];
   endfunction

   lsjc_log #(
      .LOG_FRAC_BITS(LOG_FRAC_BITS)
   ) u_log (
      .clock (clock),
      .reset (reset),
      .start (log_start),
      .value (log_value),
      .status(log_status),
      .result(log_result)
   );

   lsjc_div #(
      .WIDTH(LW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .numer   ($unsigned(num)),
      .denom   ($unsigned(den)),
      .status  (div_status),
      .quotient(div_quotient)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_sample = req_tdata;
   assign num        = log_result - lmin_ff;
   assign den        = lmax_ff - lmin_ff;
   assign t          = {2'b00, ratio_ff, 2'b00};
   assign red        = to_color(ramp(t - RED_RISE, RED_FALL - t));
   assign green      = to_color(ramp(t - GRN_RISE, GRN_FALL - t));
   assign blue       = to_color(ramp(t - BLU_RISE, BLU_FALL - t));

   always_comb begin
      state_in       = state_ff;
      stats_valid_in = stats_valid_ff;
      largest_in     = largest_ff;
      smallest_in    = smallest_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      sample_in      = sample_ff;
      black_in       = black_ff;
      lmax_in        = lmax_ff;
      lmin_in        = lmin_ff;
      ratio_in       = ratio_ff;
      log_start      = 1'b0;
      log_value      = sample_ff;
      div_start      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (!req_tuser[0]) begin
                  stats_valid_in = 1'b0;
                  if (req_tuser[1]) begin
                     largest_in  = req_sample;
                     smallest_in = (req_sample != '0) ? req_sample : '1;
                  end else begin
                     if (req_sample > largest_ff) begin
                        largest_in = req_sample;
                     end
                     if (req_sample != '0 && req_sample < smallest_ff) begin
                        smallest_in = req_sample;
                     end
                  end
               end else begin
                  sample_in = req_sample;
                  if (req_sample == '0 || largest_ff == '0) begin
                     black_in = 1'b1;
                     state_in = ST_COLOR;
                  end else begin
                     black_in  = 1'b0;
                     log_start = 1'b1;
                     if (stats_valid_ff) begin
                        log_value = req_sample;
                        state_in  = ST_LSMP;
                     end else begin
                        log_value = largest_ff;
                        state_in  = ST_LMAX;
                     end
                  end
               end
            end
         end
         ST_LMAX: begin
            if (log_status.done) begin
               lmax_in   = log_result;
               log_start = 1'b1;
               log_value = smallest_ff;
               state_in  = ST_LMIN;
            end
         end
         ST_LMIN: begin
            if (log_status.done) begin
               lmin_in        = (log_result >= lmax_ff) ? lmax_ff - LOG_1E5 : log_result;
               stats_valid_in = 1'b1;
               log_start      = 1'b1;
               log_value      = sample_ff;
               state_in       = ST_LSMP;
            end
         end
         ST_LSMP: begin
            if (log_status.done) begin
               if (num[LW-1] || num == '0) begin
                  ratio_in = '0;
                  state_in = ST_COLOR;
               end else if (num >= den) begin
                  ratio_in = '1;
                  state_in = ST_COLOR;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               ratio_in = div_quotient;
               state_in = ST_COLOR;
            end
         end
         ST_COLOR: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = black_ff ? '0 : {blue, green, red};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         stats_valid_ff <= 1'b0;
         largest_ff     <= '0;
         smallest_ff    <= '1;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         stats_valid_ff <= stats_valid_in;
         largest_ff     <= largest_in;
         smallest_ff    <= smallest_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      sample_ff   <= sample_in;
      black_ff    <= black_in;
      lmax_ff     <= lmax_in;
      lmin_ff     <= lmin_in;
      ratio_ff    <= ratio_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/lsjc_checker.sv
// Port-level checker for the log-scaled jet colormap, bound to the top level.
module lsjc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   hold_stalled_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   no_result_next_after_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared the cycle after an item");

   zero_sample_gives_black: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] && req_tdata == 32'd0 && !rsp_tvalid
      |=> ##1 (rsp_tvalid && rsp_tdata == 24'd0))
      else $error("zero sample not black");

   busy_while_result_pending: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=> !req_tready)
      else $error("item taken while color item at work");

endmodule

bind log_scaled_jet_colormap lsjc_checker u_checker (.*);
